>>> hw/rtl/afx_pkg.sv
// ----------------------------------------------------------------------------
// afx_pkg
// Shared types, codes and width helpers of the axis-aligned frame transform.
// ----------------------------------------------------------------------------
package afx_pkg;

    // fixed field widths and fixed-point constants
    localparam int COEF_W          = 16;
    localparam int WORD_W          = 32;
    localparam int PROD_W          = COEF_W + WORD_W;
    localparam int FRAC_Q14        = 14;
    localparam int HALF_Q14        = 8192;
    localparam int CFG_ADDR_W      = 3;
    localparam int COORD_WIDTH_DEF = 32;

    // xy-plane length below which the frame counts as flat
    localparam logic [COEF_W-1:0] FLAT_EPSILON = 16'd1;

    // command codes
    typedef enum logic [1:0] {
        CMD_PT_W2L  = 2'd0,
        CMD_PT_L2W  = 2'd1,
        CMD_VEC_W2L = 2'd2,
        CMD_VEC_L2W = 2'd3
    } t_cmd;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AXIS_X   = 3'd0,
        CFG_AXIS_Y   = 3'd1,
        CFG_AXIS_Z   = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } t_cfg_addr;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [2:0]              t_coef3;
    typedef t_coef [8:0]              t_rot;
    typedef logic signed [WORD_W-1:0] t_word32;
    typedef t_word32 [2:0]            t_vec32;

    // input word
    typedef struct packed {
        t_cmd                     cmd;
        logic signed [WORD_W-1:0] in_x;
        logic signed [WORD_W-1:0] in_y;
        logic signed [WORD_W-1:0] in_z;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic                     saturated;
    } t_out_word;

    // configuration write as seen by the frame unit
    typedef struct packed {
        logic                  vld;
        logic [CFG_ADDR_W-1:0] addr;
        logic [WORD_W-1:0]     data;
    } t_cfg_wr;

    // per-stage advance enables of the transform pipeline
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_pipe_en;

    // width of the added offset or origin term
    function automatic int add_width(input int cw);
        return (cw > WORD_W) ? cw : WORD_W;
    endfunction

    // width of the exact lane sum
    function automatic int acc_width(input int cw);
        int a;
        a = add_width(cw) + FRAC_Q14;
        return ((a > PROD_W + 2) ? a : PROD_W + 2) + 2;
    endfunction

    // width of the lane sum after rounding to Q16.16
    function automatic int rnd_width(input int cw);
        return acc_width(cw) - FRAC_Q14;
    endfunction

endpackage

>>> hw/rtl/afx_in_if.sv
// ----------------------------------------------------------------------------
// afx_in_if
// Input word channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface afx_in_if;
    import afx_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/afx_out_if.sv
// ----------------------------------------------------------------------------
// afx_out_if
// Result word channel: valid, ready and one transformed word.
// ----------------------------------------------------------------------------
interface afx_out_if;
    import afx_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/afx_cfg_if.sv
// ----------------------------------------------------------------------------
// afx_cfg_if
// Configuration write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface afx_cfg_if;
    import afx_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/afx_frame.sv
// ----------------------------------------------------------------------------
// afx_frame
// Configuration registers and sequential derivation of the rotation and the
// world offset: bit-serial square root, two radix-2 dividers, then a
// multiply-accumulate pass over the origin.
// ----------------------------------------------------------------------------
module afx_frame #(
    parameter int COORD_WIDTH = afx_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  afx_pkg::t_cfg_wr              i_cfg,
    output logic                          o_rdy,
    output afx_pkg::t_rot                 o_rot,
    output afx_pkg::t_vec32               o_origin,
    output logic signed [COORD_WIDTH-1:0] o_offset [3]
);
    import afx_pkg::*;

    localparam int MAC_W      = PROD_W + 2;
    localparam int MRND_W     = MAC_W - FRAC_Q14;
    localparam int OFS_W      = ((COORD_WIDTH > MRND_W + 1) ? COORD_WIDTH : MRND_W + 1) + 1;
    localparam int DIV_W      = COEF_W + FRAC_Q14;
    localparam int ROOT_STEPS = 16;
    localparam int DIV_STEPS  = DIV_W;

    localparam t_coef COEF_MAX  = 16'sh7fff;
    localparam t_coef COEF_MIN  = 16'sh8000;
    localparam t_coef COEF_ONE  = 16'sd16384;
    localparam t_coef COEF_MONE = -16'sd16384;

    localparam logic signed [OFS_W-1:0] OFS_HI =
        {{(OFS_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_LO = ~OFS_HI;

    typedef enum logic [9:0] {
        S_SQR   = 10'b00_0000_0001,
        S_SUM   = 10'b00_0000_0010,
        S_ROOT  = 10'b00_0000_0100,
        S_DLOAD = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_CS    = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_MAT   = 10'b00_1000_0000,
        S_OFS   = 10'b01_0000_0000,
        S_OFR   = 10'b10_0000_0000
    } t_state;

    // the sequencer rests in the last offset state once every row is written
    localparam t_state S_DONE_UNUSED = S_OFR;

    // control
    t_state       r_state;
    logic         r_done;
    logic [4:0]   r_cnt;
    logic [1:0]   r_row;
    logic [1:0]   r_col;

    // configuration
    t_coef        r_ax, r_ay, r_az;
    t_vec32       r_org;

    // derivation datapath
    logic [30:0]             r_pa, r_pb;
    logic [31:0]             r_n, r_r, r_bit;
    logic [COEF_W-1:0]       r_l;
    logic                    r_flat;
    logic [DIV_W-1:0]        r_dq  [2];
    logic [COEF_W-1:0]       r_rem [2];
    logic                    r_neg [2];
    t_coef                   r_c, r_s;
    logic signed [31:0]      r_pcz, r_psz;
    t_rot                    r_rot;
    logic signed [MAC_W-1:0] r_acc;
    logic signed [COORD_WIDTH-1:0] r_off [3];

    // saturate to the coefficient range
    function automatic t_coef sat16(input logic signed [19:0] v);
        if (v > COEF_MAX) return COEF_MAX;
        if (v < COEF_MIN) return COEF_MIN;
        return v[15:0];
    endfunction

    // product of two Q2.14 values back to Q2.14, half rounded up
    function automatic logic signed [19:0] rnd_q14(input logic signed [31:0] p);
        logic signed [32:0] t;
        t = 33'(p) + 33'(HALF_Q14);
        return 20'($signed(t[32:14]));
    endfunction

    // signed quotient from magnitude and sign, saturated
    function automatic t_coef sat_quot(input logic [DIV_W-1:0] q, input logic neg);
        if (!neg) return (q > DIV_W'(32767)) ? COEF_MAX : t_coef'(q[15:0]);
        return (q > DIV_W'(32768)) ? COEF_MIN : t_coef'(16'd0 - q[15:0]);
    endfunction

    // square root step
    logic [32:0] n_try;
    assign n_try = {1'b0, r_r} + {1'b0, r_bit};

    // divider steps
    logic [COEF_W:0] n_rsh [2];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_rsh[k] = {r_rem[k], r_dq[k][DIV_W-1]};
        end
    end

    // divider loads
    logic [COEF_W-1:0] n_mag [2];
    always_comb begin
        n_mag[0] = r_ay[15] ? 16'd0 - r_ay : r_ay;
        n_mag[1] = r_ax[15] ? 16'd0 - r_ax : r_ax;
    end

    // rotation entries
    t_rot n_rot;
    always_comb begin
        n_rot = '0;
        if (r_flat) begin
            n_rot[0] = COEF_ONE;
            n_rot[4] = r_az[15] ? COEF_MONE : COEF_ONE;
            n_rot[8] = r_az[15] ? COEF_MONE : COEF_ONE;
        end else begin
            n_rot[0] = r_c;
            n_rot[1] = sat16(20'sd0 - 20'(r_s));
            n_rot[3] = sat16(rnd_q14(r_psz));
            n_rot[4] = sat16(rnd_q14(r_pcz));
            n_rot[5] = sat16(20'sd0 - $signed(20'(r_l)));
            n_rot[6] = r_ax;
            n_rot[7] = r_ay;
            n_rot[8] = r_az;
        end
    end

    // offset multiply-accumulate and row finish
    logic [3:0]               n_idx;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [MAC_W-1:0]  n_acc;
    logic signed [MAC_W-1:0]  n_racc;
    logic signed [OFS_W-1:0]  n_neg;
    logic signed [COORD_WIDTH-1:0] n_off;
    always_comb begin
        n_idx  = {r_row, 1'b0} + {2'b00, r_row} + {2'b00, r_col};
        n_prod = $signed(r_rot[n_idx]) * $signed(r_org[r_col]);
        n_acc  = r_acc + MAC_W'(n_prod);
        n_racc = r_acc + MAC_W'(HALF_Q14);
        n_neg  = OFS_W'(0) - OFS_W'($signed(n_racc[MAC_W-1:FRAC_Q14]));
        if (n_neg > OFS_HI) begin
            n_off = OFS_HI[COORD_WIDTH-1:0];
        end else if (n_neg < OFS_LO) begin
            n_off = OFS_LO[COORD_WIDTH-1:0];
        end else begin
            n_off = n_neg[COORD_WIDTH-1:0];
        end
    end

    // sequencer, configuration registers and derivation datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SQR;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ax    <= '0;
            r_ay    <= '0;
            r_az    <= COEF_ONE;
            r_org   <= '0;
        end else if (i_cfg.vld) begin
            // register writes restart the derivation
            case (i_cfg.addr)
                CFG_AXIS_X: begin
                    r_ax    <= i_cfg.data[COEF_W-1:0];
                    r_state <= S_SQR;
                    r_done  <= 1'b0;
                end
                CFG_AXIS_Y: begin
                    r_ay    <= i_cfg.data[COEF_W-1:0];
                    r_state <= S_SQR;
                    r_done  <= 1'b0;
                end
                CFG_AXIS_Z: begin
                    r_az    <= i_cfg.data[COEF_W-1:0];
                    r_state <= S_SQR;
                    r_done  <= 1'b0;
                end
                CFG_ORIGIN_X: begin
                    r_org[0] <= i_cfg.data;
                    r_state  <= S_SQR;
                    r_done   <= 1'b0;
                end
                CFG_ORIGIN_Y: begin
                    r_org[1] <= i_cfg.data;
                    r_state  <= S_SQR;
                    r_done   <= 1'b0;
                end
                CFG_ORIGIN_Z: begin
                    r_org[2] <= i_cfg.data;
                    r_state  <= S_SQR;
                    r_done   <= 1'b0;
                end
                default: ;
            endcase
        end else begin
            case (r_state)
                S_SQR: begin
                    r_pa    <= 31'(r_ax * r_ax);
                    r_pb    <= 31'(r_ay * r_ay);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_n     <= {1'b0, r_pa} + {1'b0, r_pb};
                    r_r     <= '0;
                    r_bit   <= 32'h4000_0000;
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if ({1'b0, r_n} >= n_try) begin
                        r_n <= r_n - n_try[31:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ROOT_STEPS - 1)) begin
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_l    <= r_r[COEF_W-1:0];
                    r_flat <= (r_r[COEF_W-1:0] < FLAT_EPSILON) || (r_r[COEF_W-1:0] == '0);
                    r_neg[0] <= r_ay[15];
                    r_neg[1] <= r_ax[15];
                    for (int k = 0; k < 2; k++) begin
                        r_dq[k]  <= {n_mag[k], {FRAC_Q14{1'b0}}}
                                  + {{(FRAC_Q14+1){1'b0}}, r_r[COEF_W-1:1]};
                        r_rem[k] <= '0;
                    end
                    r_cnt <= '0;
                    if ((r_r[COEF_W-1:0] < FLAT_EPSILON) || (r_r[COEF_W-1:0] == '0)) begin
                        r_state <= S_MAT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < 2; k++) begin
                        if (n_rsh[k] >= {1'b0, r_l}) begin
                            r_rem[k] <= COEF_W'(n_rsh[k] - {1'b0, r_l});
                            r_dq[k]  <= {r_dq[k][DIV_W-2:0], 1'b1};
                        end else begin
                            r_rem[k] <= n_rsh[k][COEF_W-1:0];
                            r_dq[k]  <= {r_dq[k][DIV_W-2:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_CS;
                    end
                end
                S_CS: begin
                    r_c     <= sat_quot(r_dq[0], r_neg[0]);
                    r_s     <= sat_quot(r_dq[1], r_neg[1]);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pcz   <= r_c * r_az;
                    r_psz   <= r_s * r_az;
                    r_state <= S_MAT;
                end
                S_MAT: begin
                    r_rot   <= n_rot;
                    r_acc   <= '0;
                    r_row   <= '0;
                    r_col   <= '0;
                    r_state <= S_OFS;
                end
                S_OFS: begin
                    r_acc <= n_acc;
                    if (r_col == 2'd2) begin
                        r_col   <= '0;
                        r_state <= S_OFR;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_OFR: begin
                    if (!r_done) begin
                        r_off[r_row] <= n_off;
                        r_acc        <= '0;
                        if (r_row == 2'd2) begin
                            r_done <= 1'b1;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_state <= S_OFS;
                        end
                    end
                end
                default: r_state <= S_SQR;
            endcase
        end
    end

    assign o_rdy    = r_done && (r_state == S_DONE_UNUSED);
    assign o_rot    = r_rot;
    assign o_origin = r_org;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_offset[i] = r_off[i];
        end
    end

endmodule

>>> hw/rtl/afx_lane.sv
// ----------------------------------------------------------------------------
// afx_lane
// One output component: three products in the first stage, exact sum with
// the offset term and rounding to Q16.16 in the second.
// ----------------------------------------------------------------------------
module afx_lane #(
    parameter int COORD_WIDTH = afx_pkg::COORD_WIDTH_DEF
) (
    input  logic                                                i_clk,
    input  afx_pkg::t_pipe_en                                   i_en,
    input  afx_pkg::t_coef3                                     i_coef,
    input  afx_pkg::t_vec32                                     i_vec,
    input  logic signed [afx_pkg::add_width(COORD_WIDTH)-1:0]   i_add,
    output logic signed [afx_pkg::rnd_width(COORD_WIDTH)-1:0]   o_rnd
);
    import afx_pkg::*;

    localparam int ADD_W = add_width(COORD_WIDTH);
    localparam int ACC_W = acc_width(COORD_WIDTH);
    localparam int RND_W = rnd_width(COORD_WIDTH);

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ADD_W-1:0]  r_add;
    logic signed [RND_W-1:0]  r_rnd;
    logic signed [ACC_W-1:0]  n_sum;

    // stage a: coefficient times coordinate
    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= $signed(i_coef[j]) * $signed(i_vec[j]);
            end
            r_add <= i_add;
        end
    end

    // exact Q.30 sum plus half an lsb of the result
    always_comb begin
        n_sum = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2])
              + (ACC_W'(r_add) <<< FRAC_Q14) + ACC_W'(HALF_Q14);
    end

    // stage b: floor to Q16.16
    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_rnd <= n_sum[ACC_W-1:FRAC_Q14];
        end
    end

    assign o_rnd = r_rnd;

endmodule

>>> hw/rtl/afx_merge.sv
// ----------------------------------------------------------------------------
// afx_merge
// Output stage: saturates the three lane sums to the coordinate range and
// merges their clamp flags into one result word register.
// ----------------------------------------------------------------------------
module afx_merge #(
    parameter int COORD_WIDTH = afx_pkg::COORD_WIDTH_DEF
) (
    input  logic                                              i_clk,
    input  afx_pkg::t_pipe_en                                 i_en,
    input  logic signed [afx_pkg::rnd_width(COORD_WIDTH)-1:0] i_rnd [3],
    output afx_pkg::t_out_word                                o_word
);
    import afx_pkg::*;

    localparam int RND_W = rnd_width(COORD_WIDTH);

    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [RND_W-1:0] n_sat [3];
    logic [2:0]              n_clamp;
    t_out_word               r_word;

    // clamp each component
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_rnd[i] > SAT_HI) begin
                n_sat[i]   = SAT_HI;
                n_clamp[i] = 1'b1;
            end else if (i_rnd[i] < SAT_LO) begin
                n_sat[i]   = SAT_LO;
                n_clamp[i] = 1'b1;
            end else begin
                n_sat[i]   = i_rnd[i];
                n_clamp[i] = 1'b0;
            end
        end
    end

    // stage c: result word register
    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            r_word.out_x     <= n_sat[0][WORD_W-1:0];
            r_word.out_y     <= n_sat[1][WORD_W-1:0];
            r_word.out_z     <= n_sat[2][WORD_W-1:0];
            r_word.saturated <= |n_clamp;
        end
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/axis_aligned_frame_transform.sv
// ----------------------------------------------------------------------------
// axis_aligned_frame_transform
// World/local point and vector transform in a frame set by an axis and origin.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg writes the axis (Q2.14) and origin (Q16.16) registers by index; the
//   channel is always ready. Writes are expected only while no word is in
//   flight.
//   i_in takes one command word per cycle while i_in.ready is high: a
//   3-vector and one of four transforms. o_out returns one saturated word
//   per input word, in order. Three register stages (a, b, c); throughput
//   is one word per cycle while o_out is ready, set by the three lanes of
//   three multipliers each.
//   After reset and after every register write the frame unit derives the
//   rotation and offset: 16 square-root steps and 30 divider steps (both
//   quotients in parallel, skipped for a flat axis). i_in.ready stays low
//   meanwhile.
//   A stalled o_out holds its word; the three pipeline stages keep filling
//   behind it, so i_in.ready drops only once all of them are full.
// ----------------------------------------------------------------------------
module axis_aligned_frame_transform #(
    parameter int COORD_WIDTH = afx_pkg::COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    afx_in_if.sink       i_in,
    afx_out_if.source    o_out,
    afx_cfg_if.sink      i_cfg
);
    import afx_pkg::*;

    localparam int ADD_W = add_width(COORD_WIDTH);
    localparam int RND_W = rnd_width(COORD_WIDTH);

    t_cfg_wr                       cfg_wr;
    logic                          frm_rdy;
    t_rot                          frm_rot;
    t_vec32                        frm_org;
    logic signed [COORD_WIDTH-1:0] frm_off [3];

    t_pipe_en                      pen;
    logic                          r_vld_a, r_vld_b, r_vld_c;
    logic                          transpose;
    t_coef3                        sel_coef [3];
    logic signed [ADD_W-1:0]       sel_add  [3];
    t_vec32                        in_vec;
    logic signed [RND_W-1:0]       lane_rnd [3];
    t_out_word                     out_word;

    // configuration port
    assign i_cfg.ready = 1'b1;
    assign cfg_wr.vld  = i_cfg.valid;
    assign cfg_wr.addr = i_cfg.addr;
    assign cfg_wr.data = i_cfg.data;

    afx_frame #(.COORD_WIDTH(COORD_WIDTH)) u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .o_rdy    (frm_rdy),
        .o_rot    (frm_rot),
        .o_origin (frm_org),
        .o_offset (frm_off)
    );

    // stage enables collapse bubbles behind a stalled output
    assign pen.c      = !r_vld_c || o_out.ready;
    assign pen.b      = !r_vld_b || pen.c;
    assign pen.a      = !r_vld_a || pen.b;
    assign i_in.ready = frm_rdy && pen.a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (pen.a) r_vld_a <= i_in.valid && frm_rdy;
            if (pen.b) r_vld_b <= r_vld_a;
            if (pen.c) r_vld_c <= r_vld_b;
        end
    end

    // rows or columns of the rotation and the added term per lane
    assign transpose = (i_in.data.cmd == CMD_PT_L2W) || (i_in.data.cmd == CMD_VEC_L2W);
    assign in_vec[0] = i_in.data.in_x;
    assign in_vec[1] = i_in.data.in_y;
    assign in_vec[2] = i_in.data.in_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sel_coef[i][j] = transpose ? frm_rot[j*3+i] : frm_rot[i*3+j];
            end
            case (i_in.data.cmd)
                CMD_PT_W2L: sel_add[i] = ADD_W'(frm_off[i]);
                CMD_PT_L2W: sel_add[i] = ADD_W'(frm_org[i]);
                default:    sel_add[i] = '0;
            endcase
        end
    end

    // one lane per output component
    for (genvar g = 0; g < 3; g++) begin : g_lane
        afx_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
            .i_clk  (i_clk),
            .i_en   (pen),
            .i_coef (sel_coef[g]),
            .i_vec  (in_vec),
            .i_add  (sel_add[g]),
            .o_rnd  (lane_rnd[g])
        );
    end

    afx_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
        .i_clk  (i_clk),
        .i_en   (pen),
        .i_rnd  (lane_rnd),
        .o_word (out_word)
    );

    assign o_out.valid = r_vld_c;
    assign o_out.data  = out_word;

endmodule

>>> hw/rtl/afx_checker.sv
// ----------------------------------------------------------------------------
// afx_checker
// Port-level checks of the frame transform, bound to the top level.
// ----------------------------------------------------------------------------
module afx_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input afx_pkg::t_out_word           i_out_data,
    input logic                         i_cfg_valid,
    input logic                         i_cfg_ready,
    input logic [afx_pkg::CFG_ADDR_W-1:0] i_cfg_addr
);
    import afx_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result word changed while stalled");

    // register writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("configuration write stalled");

    // a register write starts a new derivation, closing the input
    a_cfg_rederive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready && (i_cfg_addr <= CFG_ORIGIN_Z) |=> !i_in_ready)
        else $error("input open right after a register write");

    // the frame is not ready straight out of reset
    a_rst_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open right after reset");

endmodule

bind axis_aligned_frame_transform afx_checker u_afx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_addr  (i_cfg.addr)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the axis-aligned frame transform: a local predictor
// tracks the axis and origin registers, derives the rotation and offset the
// same way the block does and forms each expected result word. Words are
// checked in order against o_out across several frame settings and idle
// patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import afx_pkg::*;

    localparam int     COORD_W     = COORD_WIDTH_DEF;
    localparam longint ONE_Q14     = 16384;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     SHOW_LIMIT  = 10;

    // frame and coordinate predictor with the queue of expected words
    class frame_xform_board;
        longint    axis_q14   [3];
        longint    origin_q16 [3];
        longint    rot_q14    [9];
        longint    offset_q16 [3];
        bit        frame_ok;
        t_out_word expected_words [$];
        int        mismatch_cnt;

        function new();
            axis_q14   = '{0, 0, ONE_Q14};
            origin_q16 = '{0, 0, 0};
            frame_ok   = 1'b0;
            mismatch_cnt = 0;
        endfunction

        function longint clamp_coef(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint clamp_coord(longint v, inout bit clip);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                clip = 1'b1;
                return hi;
            end
            if (v < lo) begin
                clip = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // divide by 2^14, ties toward +inf
        function longint shift_q14(longint v);
            return (v + HALF_Q14) >>> FRAC_Q14;
        endfunction

        function longint root_floor(longint n);
            longint unsigned rem;
            longint unsigned res;
            longint unsigned one_bit;
            rem = n;
            res = 0;
            one_bit = 64'd1 << 62;
            while (one_bit > rem) one_bit >>= 2;
            while (one_bit != 0) begin
                if (rem >= res + one_bit) begin
                    rem -= res + one_bit;
                    res = (res >> 1) + one_bit;
                end else begin
                    res >>= 1;
                end
                one_bit >>= 2;
            end
            return longint'(res);
        endfunction

        // a*2^14 / l, ties away from zero
        function longint div_q14(longint a, longint l);
            longint num;
            longint mag;
            longint q;
            num = a * ONE_Q14;
            mag = (num < 0) ? -num : num;
            q = (mag + l / 2) / l;
            return (num < 0) ? -q : q;
        endfunction

        // rotation from the axis, then offset = -R * origin
        function void derive_frame();
            longint l;
            longint c;
            longint s;
            longint acc;
            bit     unused_clip;
            l = root_floor(axis_q14[0] * axis_q14[0] + axis_q14[1] * axis_q14[1]);
            if (l < longint'(FLAT_EPSILON) || l == 0) begin
                foreach (rot_q14[k]) rot_q14[k] = 0;
                rot_q14[0] = ONE_Q14;
                rot_q14[4] = (axis_q14[2] < 0) ? -ONE_Q14 : ONE_Q14;
                rot_q14[8] = (axis_q14[2] < 0) ? -ONE_Q14 : ONE_Q14;
            end else begin
                c = clamp_coef(div_q14(axis_q14[1], l));
                s = clamp_coef(div_q14(axis_q14[0], l));
                rot_q14[0] = c;
                rot_q14[1] = clamp_coef(-s);
                rot_q14[2] = 0;
                rot_q14[3] = clamp_coef(shift_q14(s * axis_q14[2]));
                rot_q14[4] = clamp_coef(shift_q14(c * axis_q14[2]));
                rot_q14[5] = clamp_coef(-l);
                rot_q14[6] = clamp_coef(axis_q14[0]);
                rot_q14[7] = clamp_coef(axis_q14[1]);
                rot_q14[8] = clamp_coef(axis_q14[2]);
            end
            unused_clip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += rot_q14[i * 3 + j] * origin_q16[j];
                offset_q16[i] = clamp_coord(-shift_q14(acc), unused_clip);
            end
            frame_ok = 1'b1;
        endfunction

        function void set_reg(t_cfg_addr idx, logic [WORD_W-1:0] val);
            case (idx)
                CFG_AXIS_X:   axis_q14[0]   = longint'($signed(val[COEF_W-1:0]));
                CFG_AXIS_Y:   axis_q14[1]   = longint'($signed(val[COEF_W-1:0]));
                CFG_AXIS_Z:   axis_q14[2]   = longint'($signed(val[COEF_W-1:0]));
                CFG_ORIGIN_X: origin_q16[0] = longint'($signed(val));
                CFG_ORIGIN_Y: origin_q16[1] = longint'($signed(val));
                CFG_ORIGIN_Z: origin_q16[2] = longint'($signed(val));
                default: return;
            endcase
            frame_ok = 1'b0;
        endfunction

        // accepted input word: predict its result word
        function void note_word(t_in_word w);
            longint    v   [3];
            longint    add [3];
            longint    r   [3];
            longint    acc;
            longint    m;
            bit        transposed;
            bit        clip;
            t_out_word e;
            if (!frame_ok) derive_frame();
            v[0] = w.in_x;
            v[1] = w.in_y;
            v[2] = w.in_z;
            transposed = (w.cmd == CMD_PT_L2W || w.cmd == CMD_VEC_L2W);
            case (w.cmd)
                CMD_PT_W2L: add = offset_q16;
                CMD_PT_L2W: add = origin_q16;
                default:    add = '{0, 0, 0};
            endcase
            clip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc = add[i] * ONE_Q14;
                for (int j = 0; j < 3; j++) begin
                    m = transposed ? rot_q14[j * 3 + i] : rot_q14[i * 3 + j];
                    acc += m * v[j];
                end
                r[i] = clamp_coord(shift_q14(acc), clip);
            end
            e.out_x     = r[0][WORD_W-1:0];
            e.out_y     = r[1][WORD_W-1:0];
            e.out_z     = r[2][WORD_W-1:0];
            e.saturated = clip;
            expected_words.push_back(e);
        endfunction

        function void flag_mismatch(string msg);
            mismatch_cnt++;
            if (mismatch_cnt <= SHOW_LIMIT) $display("%s", msg);
        endfunction

        // result word: compare with the oldest prediction
        function void check_word(t_out_word got);
            t_out_word e;
            if (expected_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word: %0d %0d %0d sat %0b",
                                        got.out_x, got.out_y, got.out_z, got.saturated));
                return;
            end
            e = expected_words.pop_front();
            if (got.out_x !== e.out_x || got.out_y !== e.out_y ||
                got.out_z !== e.out_z || got.saturated !== e.saturated) begin
                flag_mismatch($sformatf(
                    "result mismatch: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                    e.out_x, e.out_y, e.out_z, e.saturated,
                    got.out_x, got.out_y, got.out_z, got.saturated));
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // frame setting: axis Q2.14, origin Q16.16
    typedef struct {
        int ax, ay, az;
        int ox, oy, oz;
    } t_frame_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;

    afx_in_if  in_ch ();
    afx_out_if out_ch ();
    afx_cfg_if cfg_ch ();

    frame_xform_board board = new();

    int   src_idle_pct;
    int   snk_stall_pct;
    int   cycle_cnt = 0;
    t_cmd all_cmds [4] = '{CMD_PT_W2L, CMD_PT_L2W, CMD_VEC_W2L, CMD_VEC_L2W};

    axis_aligned_frame_transform u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** axis_aligned_frame_transform: FAILED **");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic t_word32 pick_coord();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(131071) - 65536;
            3: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_axis();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    // present one input word, hold until accepted
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_word(w);
    endtask

    task automatic feed_random(int count);
        t_in_word w;
        repeat (count) begin
            w.cmd  = all_cmds[$urandom_range(3)];
            w.in_x = pick_coord();
            w.in_y = pick_coord();
            w.in_z = pick_coord();
            send_word(w);
        end
    endtask

    // hold off input until every predicted word has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all six frame registers back to back
    task automatic load_frame(t_frame_setting fs);
        t_cfg_addr         regs [6];
        logic [WORD_W-1:0] vals [6];
        regs = '{CFG_AXIS_X, CFG_AXIS_Y, CFG_AXIS_Z,
                 CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z};
        vals = '{fs.ax, fs.ay, fs.az, fs.ox, fs.oy, fs.oz};
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            board.set_reg(regs[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        t_in_word       w;
        t_word32        edge_vals [4][3];
        t_frame_setting frames    [8];
        t_frame_setting fs;

        edge_vals = '{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
                      '{32'sh80000000, 32'sh80000000, 32'sh80000000},
                      '{0, 0, 0},
                      '{1, -1, 32'sh80000000}};
        frames[0] = '{9459, 9459, 9459, 100 <<< 16, -50 <<< 16, 25 <<< 16};
        frames[1] = '{0, 0, -16384, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
        frames[2] = '{16384, 0, 0, 0, 0, 0};
        frames[3] = '{-32768, 32767, -32768, 32'h80000000, 32'h80000000, 32'h80000000};
        frames[4] = '{0, 0, 0, $urandom, $urandom, $urandom};
        frames[5] = '{1, 0, 16384, 12345, -67890, 3 <<< 16};
        frames[6] = '{0, -16384, 0, -1, -1, -1};
        frames[7] = '{pick_axis(), pick_axis(), pick_axis(), $urandom, $urandom, $urandom};

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.addr   <= CFG_AXIS_X;
        cfg_ch.data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame: every command against the coordinate extremes
        foreach (all_cmds[c]) begin
            for (int k = 0; k < 4; k++) begin
                w.cmd  = all_cmds[c];
                w.in_x = edge_vals[k][0];
                w.in_y = edge_vals[k][1];
                w.in_z = edge_vals[k][2];
                send_word(w);
            end
        end
        feed_random(60);

        // one phase per frame setting, rotating through idle patterns
        foreach (frames[p]) begin
            case (p % 4)
                0: begin src_idle_pct = 87; snk_stall_pct = 0;  end
                1: begin src_idle_pct = 0;  snk_stall_pct = 87; end
                2: begin src_idle_pct = 22; snk_stall_pct = 22; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            wait_drained();
            fs = frames[p];
            load_frame(fs);
            feed_random(100);
        end

        // drain and settle
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatch_cnt == 0 && board.pending() == 0) begin
            $display("** axis_aligned_frame_transform: PASSED **");
        end else begin
            $display("** axis_aligned_frame_transform: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/afx_pkg.sv
hw/rtl/afx_in_if.sv
hw/rtl/afx_out_if.sv
hw/rtl/afx_cfg_if.sv
hw/rtl/afx_frame.sv
hw/rtl/afx_lane.sv
hw/rtl/afx_merge.sv
hw/rtl/axis_aligned_frame_transform.sv
hw/rtl/afx_checker.sv
test/testbench.sv
